>>> hw/rtl/crrt_pkg.sv
// Shared types and constants of the completion ring reorder tracker.
// Depends on nothing; imported by the tracker core.
`default_nettype none

package crrt_pkg;

    localparam int unsigned FIELD_W    = 16;
    localparam int unsigned ADDR_W     = 64;
    localparam int unsigned SIZE_LOG_W = 4;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_DONE  = 2'd1,
        REQ_TAIL  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_OOO      = 2'd2,
        STS_IN_ORDER = 2'd3
    } t_status;

    // Configuration register indexes.
    localparam logic CFG_BASE     = 1'b0;
    localparam logic CFG_SIZE_LOG = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/completion_ring_reorder_tracker_core.sv
// Completion ring reorder tracker: issue pointer, host tail and committed head,
// with the done bitmap held in crrt_done_map. Depends on crrt_pkg.
//
// Usage. Requests enter on the input channel (i_in_valid / o_in_ready) and
// each request yields exactly one result on the output channel
// (o_out_valid / i_out_ready). One request is worked on at a time.
// Path from acceptance to the result register:
//   - tail write, unused kind, rejected allocate, out-of-order done: the
//     result register is loaded directly on acceptance;
//   - allocate that issues a write: slot offset product, then the 64-bit
//     address add;
//   - in-order done: a walk past further done slots, reading one bitmap
//     entry per cycle through the single read port of the done memory.
// A new request is taken once the result register is empty or being drained,
// so a stalled receiver simply holds off the next request.
// After reset the done memory is swept to zero, one entry per cycle, all
// 2**MAX_SIZE_LOG entries (4096 at the default); no request is accepted
// meanwhile. Configuration writes are taken at any time and should only be
// issued while the block is idle.
`default_nettype none

module completion_ring_reorder_tracker_core #(
    parameter int MAX_SIZE_LOG = 12,
    parameter int ENTRY_BYTES  = 32,
    parameter int POINTER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_done_tag,
    input  logic [15:0] i_host_pointer,
    input  logic [15:0] i_entry_index,
    input  logic [15:0] i_entry_length,
    input  logic        i_entry_is_tx,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_write_valid,
    output logic [63:0] o_write_address,
    output logic [15:0] o_write_tag,
    output logic [15:0] o_write_index,
    output logic [15:0] o_write_length,
    output logic        o_write_is_tx,
    output logic        o_head_advanced,
    output logic [15:0] o_committed_head
);

    import crrt_pkg::*;

    localparam int CNT_W  = MAX_SIZE_LOG + 1;
    localparam int LG_W   = $clog2(MAX_SIZE_LOG + 1);
    localparam int CMP_W  = (POINTER_BITS > CNT_W) ? POINTER_BITS : CNT_W;
    localparam int SW     = (POINTER_BITS > MAX_SIZE_LOG) ? POINTER_BITS : MAX_SIZE_LOG;
    localparam int TW     = (POINTER_BITS > FIELD_W) ? POINTER_BITS : FIELD_W;
    localparam int EB_W   = $clog2(ENTRY_BYTES + 1);
    localparam int PROD_W = MAX_SIZE_LOG + EB_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_WALK
    } t_state;

    typedef logic [POINTER_BITS-1:0] t_ptr;
    typedef logic [MAX_SIZE_LOG-1:0] t_slot;

    function automatic t_slot slot_of(input t_ptr ptr, input t_slot msk);
        return MAX_SIZE_LOG'(SW'(ptr)) & msk;
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input t_ptr ptr);
        return FIELD_W'(TW'(ptr));
    endfunction

    // Registers and their next values.
    t_state                  r_state, n_state;
    logic [ADDR_W-1:0]       r_base, n_base;
    logic [SIZE_LOG_W-1:0]   r_size_log, n_size_log;
    t_ptr                    r_head, n_head;
    t_ptr                    r_issue, n_issue;
    t_ptr                    r_tail, n_tail;
    t_slot                   r_slot, n_slot;
    logic [CNT_W-1:0]        r_steps, n_steps;
    logic [PROD_W-1:0]       r_prod, n_prod;
    logic                    r_out_valid, n_out_valid;
    t_status                 r_status, n_status;
    logic                    r_wvalid, n_wvalid;
    logic [ADDR_W-1:0]       r_waddr, n_waddr;
    logic [FIELD_W-1:0]      r_wtag, n_wtag;
    logic [FIELD_W-1:0]      r_windex, n_windex;
    logic [FIELD_W-1:0]      r_wlen, n_wlen;
    logic                    r_wtx, n_wtx;
    logic                    r_hadv, n_hadv;
    logic [FIELD_W-1:0]      r_chead, n_chead;

    // Derived values and memory controls.
    logic [LG_W-1:0]   w_lg;
    logic [CNT_W-1:0]  w_count;
    t_slot             w_smask;
    t_ptr              w_used;
    logic              w_full;
    t_ptr              w_tag;
    t_slot             w_head_slot;
    logic              w_in_acc;
    logic              w_map_busy;
    logic              w_rd_bit;
    logic              w_wr_en;
    t_slot             w_wr_addr;
    logic              w_wr_bit;
    logic              w_rd_en;
    t_slot             w_rd_addr;

    assign w_lg = (r_size_log > MAX_SIZE_LOG) ? LG_W'(MAX_SIZE_LOG) : LG_W'(r_size_log);
    assign w_count     = CNT_W'(1) << w_lg;
    assign w_smask     = MAX_SIZE_LOG'(w_count - CNT_W'(1));
    assign w_used      = r_issue - r_tail;
    assign w_full      = CMP_W'(w_used) >= CMP_W'(w_count);
    assign w_tag       = POINTER_BITS'(TW'(i_done_tag));
    assign w_head_slot = slot_of(r_head, w_smask);

    // The result register is free for the next request once it is empty or
    // being drained in this cycle.
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_acc   = i_in_valid && o_in_ready;

    crrt_done_map #(
        .AW (MAX_SIZE_LOG)
    ) u_done_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_bit  (w_wr_bit),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_bit  (w_rd_bit),
        .o_busy    (w_map_busy)
    );

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_size_log  = r_size_log;
        n_head      = r_head;
        n_issue     = r_issue;
        n_tail      = r_tail;
        n_slot      = r_slot;
        n_steps     = r_steps;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_wvalid    = r_wvalid;
        n_waddr     = r_waddr;
        n_wtag      = r_wtag;
        n_windex    = r_windex;
        n_wlen      = r_wlen;
        n_wtx       = r_wtx;
        n_hadv      = r_hadv;
        n_chead     = r_chead;
        w_wr_en     = 1'b0;
        w_wr_addr   = w_head_slot;
        w_wr_bit    = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_slot;

        if (i_cfg_we) begin
            if (i_cfg_index == CFG_BASE) begin
                n_base = i_cfg_data;
            end else begin
                n_size_log = i_cfg_data[SIZE_LOG_W-1:0];
            end
        end

        case (r_state)
            S_CLEAR: begin
                if (!w_map_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    // Fields of a result that issues no write read as zero.
                    n_wvalid = 1'b0;
                    n_waddr  = '0;
                    n_wtag   = '0;
                    n_windex = '0;
                    n_wlen   = '0;
                    n_wtx    = 1'b0;
                    n_hadv   = 1'b0;
                    n_chead  = to_field(r_head);
                    case (t_req'(i_req_type))
                        REQ_ALLOC: begin
                            if (w_full) begin
                                n_status    = STS_FULL;
                                n_out_valid = 1'b1;
                            end else begin
                                n_prod   = PROD_W'(slot_of(r_issue, w_smask))
                                           * PROD_W'(ENTRY_BYTES);
                                n_wtag   = to_field(r_issue);
                                n_windex = i_entry_index;
                                n_wlen   = i_entry_length;
                                n_wtx    = i_entry_is_tx;
                                n_issue  = r_issue + 1'b1;
                                n_state  = S_ALLOC;
                            end
                        end
                        REQ_DONE: begin
                            if (w_tag != r_head) begin
                                w_wr_en     = 1'b1;
                                w_wr_addr   = slot_of(w_tag, w_smask);
                                w_wr_bit    = 1'b1;
                                n_status    = STS_OOO;
                                n_out_valid = 1'b1;
                            end else begin
                                // Retire the head slot and fetch the next one.
                                w_wr_en   = 1'b1;
                                w_wr_addr = w_head_slot;
                                n_head    = r_head + 1'b1;
                                n_steps   = CNT_W'(1);
                                n_slot    = MAX_SIZE_LOG'(w_head_slot + 1'b1) & w_smask;
                                w_rd_en   = 1'b1;
                                w_rd_addr = n_slot;
                                n_state   = S_WALK;
                            end
                        end
                        REQ_TAIL: begin
                            n_tail      = POINTER_BITS'(TW'(i_host_pointer));
                            n_status    = STS_OK;
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_status    = STS_OK;
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                n_waddr     = r_base + ADDR_W'(r_prod);
                n_wvalid    = 1'b1;
                n_status    = STS_OK;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_WALK: begin
                // The bit of r_slot arrives this cycle; the walk stops at the
                // first slot not yet done or after one full turn.
                if (w_rd_bit && (r_steps < w_count)) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_slot;
                    n_head    = r_head + 1'b1;
                    n_steps   = r_steps + 1'b1;
                    n_slot    = MAX_SIZE_LOG'(r_slot + 1'b1) & w_smask;
                    w_rd_en   = 1'b1;
                    w_rd_addr = n_slot;
                end else begin
                    n_status    = STS_IN_ORDER;
                    n_hadv      = 1'b1;
                    n_chead     = to_field(r_head);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_steps  <= n_steps;
        r_prod   <= n_prod;
        r_status <= n_status;
        r_wvalid <= n_wvalid;
        r_waddr  <= n_waddr;
        r_wtag   <= n_wtag;
        r_windex <= n_windex;
        r_wlen   <= n_wlen;
        r_wtx    <= n_wtx;
        r_hadv   <= n_hadv;
        r_chead  <= n_chead;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_base      <= '0;
            r_size_log  <= '0;
            r_head      <= '0;
            r_issue     <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_size_log  <= n_size_log;
            r_head      <= n_head;
            r_issue     <= n_issue;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_write_valid    = r_wvalid;
    assign o_write_address  = r_waddr;
    assign o_write_tag      = r_wtag;
    assign o_write_index    = r_windex;
    assign o_write_length   = r_wlen;
    assign o_write_is_tx    = r_wtx;
    assign o_head_advanced  = r_hadv;
    assign o_committed_head = r_chead;

endmodule

`default_nettype wire

>>> hw/rtl/crrt_done_map.sv
// Done bitmap of the completion ring: a one-bit synchronous memory with a
// registered read port and a clearing sweep after reset. Depends on nothing.
`default_nettype none

module crrt_done_map #(
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_wr_bit,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic          o_rd_bit,
    output logic          o_busy
);

    logic          r_mem [2**AW];
    logic          r_busy;
    logic [AW-1:0] r_clr_addr;
    logic          r_rd_bit;

    // After reset every entry is written to zero, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {AW{1'b1}}) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_bit;
        end
        if (i_rd_en) begin
            r_rd_bit <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_bit = r_rd_bit;
    assign o_busy   = r_busy;

endmodule

`default_nettype wire
